/* hdl/appliance_frame_receiver_top_macros.svh */
// Assertion macros for the appliance frame receiver.
// Used by appliance_frame_receiver_top.sv; expects clk and rst_n in scope.
`ifndef APPLIANCE_FRAME_RECEIVER_TOP_MACROS_SVH
`define APPLIANCE_FRAME_RECEIVER_TOP_MACROS_SVH
`ifndef SYNTH
// A condition that holds at every clock edge outside reset.
`define AFR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that implies another in the same cycle.
`define AFR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// A condition that implies another in the following cycle.
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AFR_ASSERT_ALWAYS(lbl, cond, msg)
`define AFR_ASSERT_IMPLY(lbl, ante, cons, msg)
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/afr_pkg.sv */
// Package for the appliance frame receiver: frame constants, kinds and status layout.
// Has no dependencies; imported by appliance_frame_receiver_top.
package afr_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'hAA;
    localparam logic [7:0] ID_NET_REQUEST = 8'h63;
    localparam logic [7:0] ID_STATUS      = 8'hC8;
    localparam logic [7:0] ID_HS_FIRST    = 8'h07;
    localparam logic [7:0] ID_HS_SECOND   = 8'hA0;
    localparam logic [7:0] ID_HS_THIRD    = 8'h05;
    localparam logic [7:0] TARGET_MAX     = 8'd99;
    localparam logic [7:0] LEN_MIN        = 8'd2;
    localparam logic [7:0] LEN_MAX        = 8'd254;
    localparam logic [7:0] POS_LENGTH     = 8'd1;
    localparam logic [7:0] POS_FIRST_DATA = 8'd2;

    localparam int NUM_SLOTS  = 9;
    localparam int OUT_BYTES  = 7;

    // Slot numbers of the captured frame positions.
    localparam logic [3:0] SLOT_B9  = 4'd0;
    localparam logic [3:0] SLOT_B10 = 4'd1;
    localparam logic [3:0] SLOT_B11 = 4'd2;
    localparam logic [3:0] SLOT_B12 = 4'd3;
    localparam logic [3:0] SLOT_B13 = 4'd4;
    localparam logic [3:0] SLOT_B17 = 4'd5;
    localparam logic [3:0] SLOT_B19 = 4'd6;
    localparam logic [3:0] SLOT_B26 = 4'd7;
    localparam logic [3:0] SLOT_B31 = 4'd8;

    typedef enum logic [2:0] {
        KIND_NET_REQUEST = 3'd0,
        KIND_STATUS      = 3'd1,
        KIND_HS_FIRST    = 3'd2,
        KIND_HS_SECOND   = 3'd3,
        KIND_HS_THIRD    = 3'd4,
        KIND_OTHER       = 3'd5
    } frame_kind_t;

    localparam logic [1:0] HS_NONE     = 2'd0;
    localparam logic [1:0] HS_FIRST    = 2'd1;
    localparam logic [1:0] HS_SECOND   = 2'd2;
    localparam logic [1:0] HS_COMPLETE = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } slot_sel_t;

    // Latched appliance status, 37 bits.
    typedef struct packed {
        logic       filter_request;
        logic [7:0] fault_code;
        logic [7:0] measured_humidity;
        logic [6:0] target_humidity;
        logic [6:0] fan_level;
        logic [3:0] run_mode;
        logic       pump_on;
        logic       power_on;
    } status_t;

    // Maps a frame position to its capture slot.
    function automatic slot_sel_t slot_of(input logic [7:0] pos);
        slot_sel_t s;
        s.hit = 1'b1;
        s.idx = SLOT_B9;
        case (pos)
            8'd9:    s.idx = SLOT_B9;
            8'd10:   s.idx = SLOT_B10;
            8'd11:   s.idx = SLOT_B11;
            8'd12:   s.idx = SLOT_B12;
            8'd13:   s.idx = SLOT_B13;
            8'd17:   s.idx = SLOT_B17;
            8'd19:   s.idx = SLOT_B19;
            8'd26:   s.idx = SLOT_B26;
            8'd31:   s.idx = SLOT_B31;
            default: s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

/* hdl/appliance_frame_receiver_top.sv */
// Appliance frame receiver: a byte stream in, one result request per completed frame out.
// Depends on afr_pkg and on appliance_frame_receiver_top_macros.svh.
//
// Usage: received serial bytes enter on the s_* channel, one byte per request.
// A byte 0xAA starts a frame anywhere, the next byte is the length L (2 to 254,
// others drop the frame), and L-1 more bytes follow. On the last byte of a frame
// the block sends one request on the m_* channel that carries the frame kind,
// the handshake step, the length and the latched appliance status. Other bytes
// give no output.
// Timing: an accepted byte is held in the input register and decoded from there;
// the result is loaded into the output register, which drives m_tvalid.
// Throughput: one byte per cycle while no finished result waits on a stalled
// receiver, set by the single decode step between the input and output registers.
// Reset clears the frame tracker, the captured bytes, the handshake step and the
// latched status to zero, and empties both registers.
// When the receiver stalls, the finished result is held in the output register
// and one more byte is still taken into the input register; bytes that do not
// end a frame keep flowing through, and only a second finished frame waits.
`include "appliance_frame_receiver_top_macros.svh"

module appliance_frame_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [2:0] frame_kind, [4:3] handshake_step,
                                   // [12:5] frame_length, [13] power_on,
                                   // [14] pump_on, [18:15] run_mode,
                                   // [25:19] fan_level, [32:26] target_humidity,
                                   // [40:33] measured_humidity, [48:41] fault_code,
                                   // [49] filter_request, [55:50] zero
);
    import afr_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame tracker state.
    logic       in_frame_reg,  in_frame_next;
    logic [7:0] pos_reg,       pos_next;
    logic [7:0] left_reg,      left_next;
    logic [7:0] len_reg,       len_next;
    logic [1:0] hs_reg,        hs_next;
    status_t    status_reg,    status_next;
    logic [7:0] cap_reg  [NUM_SLOTS];
    logic [7:0] cap_next [NUM_SLOTS];

    // Output register.
    logic                   out_valid_reg;
    logic [OUT_BYTES*8-1:0] out_data_reg;
    logic [OUT_BYTES*8-1:0] out_data_next;

    logic        data_phase;
    logic        do_capture;
    logic        produce;
    logic        out_free;
    logic        step_fire;
    logic        out_load;
    slot_sel_t   slot;
    frame_kind_t kind;

    // A data byte is any non-sync byte inside a frame past the length byte.
    assign data_phase = in_frame_reg && (in_byte_reg != SYNC_BYTE)
                        && (pos_reg != POS_LENGTH) && (left_reg != 8'd0);
    assign do_capture = data_phase;
    assign produce    = data_phase && (left_reg == 8'd1);
    assign slot       = slot_of(pos_reg);

    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && (!produce || out_free);
    assign out_load  = step_fire && produce;
    assign s_tready  = !in_valid_reg || step_fire;

    // Captured bytes including the byte now being decoded.
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (do_capture && slot.hit && (slot.idx == 4'(i)))
            begin
                cap_next[i] = in_byte_reg;
            end
            else
            begin
                cap_next[i] = cap_reg[i];
            end
        end
    end

    // Frame classification, checked in priority order.
    always_comb
    begin
        if (cap_next[SLOT_B9] == ID_NET_REQUEST)
        begin
            kind = KIND_NET_REQUEST;
        end
        else if (cap_next[SLOT_B10] == ID_STATUS)
        begin
            kind = KIND_STATUS;
        end
        else if (cap_next[SLOT_B9] == ID_HS_FIRST)
        begin
            kind = KIND_HS_FIRST;
        end
        else if (cap_next[SLOT_B9] == ID_HS_SECOND)
        begin
            kind = KIND_HS_SECOND;
        end
        else if (cap_next[SLOT_B9] == ID_HS_THIRD)
        begin
            kind = KIND_HS_THIRD;
        end
        else
        begin
            kind = KIND_OTHER;
        end
    end

    // Next state of the frame tracker.
    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        left_next     = left_reg;
        len_next      = len_reg;
        hs_next       = hs_reg;
        status_next   = status_reg;

        if (in_byte_reg == SYNC_BYTE)
        begin
            in_frame_next = 1'b1;
            pos_next      = POS_LENGTH;
            left_next     = 8'd0;
        end
        else if (in_frame_reg)
        begin
            if (pos_reg == POS_LENGTH)
            begin
                if ((in_byte_reg < LEN_MIN) || (in_byte_reg > LEN_MAX))
                begin
                    in_frame_next = 1'b0;
                    pos_next      = 8'd0;
                    left_next     = 8'd0;
                end
                else
                begin
                    len_next  = in_byte_reg;
                    left_next = in_byte_reg - 8'd1;
                    pos_next  = POS_FIRST_DATA;
                end
            end
            else if (left_reg > 8'd1)
            begin
                pos_next  = pos_reg + 8'd1;
                left_next = left_reg - 8'd1;
            end
            else if (left_reg == 8'd0)
            begin
                in_frame_next = 1'b0;
                pos_next      = 8'd0;
            end
            else
            begin
                // Last byte of the frame.
                in_frame_next = 1'b0;
                pos_next      = 8'd0;
                left_next     = 8'd0;
                case (kind)
                    KIND_STATUS:
                    begin
                        status_next.power_on          = cap_next[SLOT_B11][0];
                        status_next.pump_on           = cap_next[SLOT_B19][3];
                        status_next.run_mode          = cap_next[SLOT_B12][3:0];
                        status_next.fan_level         = cap_next[SLOT_B13][6:0];
                        status_next.target_humidity   =
                            (cap_next[SLOT_B17] > TARGET_MAX) ? TARGET_MAX[6:0]
                                                              : cap_next[SLOT_B17][6:0];
                        status_next.measured_humidity = cap_next[SLOT_B26];
                        status_next.fault_code        = cap_next[SLOT_B31];
                        status_next.filter_request    = cap_next[SLOT_B19][7];
                    end
                    KIND_HS_FIRST:  hs_next = HS_FIRST;
                    KIND_HS_SECOND: hs_next = HS_SECOND;
                    KIND_HS_THIRD:  hs_next = HS_COMPLETE;
                    default:        hs_next = hs_reg;
                endcase
            end
        end
    end

    // Result word, packed from the lowest field up.
    assign out_data_next = {6'd0,
                            status_next.filter_request,
                            status_next.fault_code,
                            status_next.measured_humidity,
                            status_next.target_humidity,
                            status_next.fan_level,
                            status_next.run_mode,
                            status_next.pump_on,
                            status_next.power_on,
                            len_next,
                            hs_next,
                            kind};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= 8'd0;
            left_reg     <= 8'd0;
            len_reg      <= 8'd0;
            hs_reg       <= HS_NONE;
            status_reg   <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                cap_reg[i] <= 8'd0;
            end
        end
        else if (step_fire)
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            left_reg     <= left_next;
            len_reg      <= len_next;
            hs_reg       <= hs_next;
            status_reg   <= status_next;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                cap_reg[i] <= cap_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A waiting result is never overwritten.
    `AFR_ASSERT_IMPLY(a_no_overwrite, out_valid_reg && !m_tready, !out_load,
                      "result overwritten while stalled")
    // After a result the tracker is back to hunting for sync.
    `AFR_ASSERT_NEXT(a_hunt_after_result, out_load, !in_frame_reg,
                     "frame not closed after result")
    // Past the length byte a frame always has bytes still due.
    `AFR_ASSERT_IMPLY(a_left_nonzero, in_frame_reg && (pos_reg != POS_LENGTH),
                      left_reg != 8'd0, "frame lost its byte count")
    // The setpoint stays clamped.
    `AFR_ASSERT_ALWAYS(a_target_clamped, status_reg.target_humidity <= TARGET_MAX[6:0],
                       "setpoint above clamp")

endmodule

/* verif/afr_frame_checker.sv */
// Scoreboard for the appliance frame receiver: watches both stream channels, predicts results.
// Depends on afr_pkg for the frame constants, the frame kinds and the status layout.
`timescale 1ns / 1ps

module afr_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);
    import afr_pkg::*;

    typedef struct packed {
        frame_kind_t kind;
        logic [1:0]  step;
        logic [7:0]  length;
        status_t     status;
    } frame_report_t;

    // Predicted state of the frame tracker.
    logic        in_frame;
    logic [7:0]  next_pos;
    logic [7:0]  bytes_due;
    logic [7:0]  frame_len;
    logic [7:0]  slots [NUM_SLOTS];
    logic [1:0]  hs_step;
    status_t     latched;

    frame_report_t expected_reports[$];

    function automatic int slot_index(input logic [7:0] pos);
        case (pos)
            8'd9:    return int'(SLOT_B9);
            8'd10:   return int'(SLOT_B10);
            8'd11:   return int'(SLOT_B11);
            8'd12:   return int'(SLOT_B12);
            8'd13:   return int'(SLOT_B13);
            8'd17:   return int'(SLOT_B17);
            8'd19:   return int'(SLOT_B19);
            8'd26:   return int'(SLOT_B26);
            8'd31:   return int'(SLOT_B31);
            default: return -1;
        endcase
    endfunction

    // Advances the predicted tracker by one received byte and queues a report
    // when the byte closes a frame.
    task automatic absorb_byte(input logic [7:0] b);
        frame_report_t r;
        int            s;
        if (b == SYNC_BYTE)
        begin
            in_frame  = 1'b1;
            next_pos  = POS_LENGTH;
            bytes_due = 8'd0;
        end
        else if (!in_frame)
        begin
            // Hunting for sync: the byte is dropped.
        end
        else if (next_pos == POS_LENGTH)
        begin
            if (b < LEN_MIN || b > LEN_MAX)
            begin
                in_frame  = 1'b0;
                next_pos  = 8'd0;
                bytes_due = 8'd0;
            end
            else
            begin
                frame_len = b;
                bytes_due = b - 8'd1;
                next_pos  = POS_FIRST_DATA;
            end
        end
        else if (bytes_due == 8'd0)
        begin
            in_frame = 1'b0;
            next_pos = 8'd0;
        end
        else
        begin
            s = slot_index(next_pos);
            if (s >= 0)
                slots[s] = b;
            if (bytes_due > 8'd1)
            begin
                next_pos  = next_pos + 8'd1;
                bytes_due = bytes_due - 8'd1;
            end
            else
            begin
                if (slots[SLOT_B9] == ID_NET_REQUEST)
                begin
                    r.kind = KIND_NET_REQUEST;
                end
                else if (slots[SLOT_B10] == ID_STATUS)
                begin
                    r.kind                    = KIND_STATUS;
                    latched.power_on          = slots[SLOT_B11][0];
                    latched.pump_on           = slots[SLOT_B19][3];
                    latched.run_mode          = slots[SLOT_B12][3:0];
                    latched.fan_level         = slots[SLOT_B13][6:0];
                    latched.target_humidity   = (slots[SLOT_B17] > TARGET_MAX) ?
                                                TARGET_MAX[6:0] : slots[SLOT_B17][6:0];
                    latched.measured_humidity = slots[SLOT_B26];
                    latched.fault_code        = slots[SLOT_B31];
                    latched.filter_request    = slots[SLOT_B19][7];
                end
                else if (slots[SLOT_B9] == ID_HS_FIRST)
                begin
                    r.kind  = KIND_HS_FIRST;
                    hs_step = HS_FIRST;
                end
                else if (slots[SLOT_B9] == ID_HS_SECOND)
                begin
                    r.kind  = KIND_HS_SECOND;
                    hs_step = HS_SECOND;
                end
                else if (slots[SLOT_B9] == ID_HS_THIRD)
                begin
                    r.kind  = KIND_HS_THIRD;
                    hs_step = HS_COMPLETE;
                end
                else
                begin
                    r.kind = KIND_OTHER;
                end
                in_frame  = 1'b0;
                next_pos  = 8'd0;
                bytes_due = 8'd0;
                r.step    = hs_step;
                r.length  = frame_len;
                r.status  = latched;
                expected_reports.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch in %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_result(input logic [55:0] d);
        frame_report_t e;
        if (expected_reports.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: tdata %h", d);
        end
        else
        begin
            e = expected_reports.pop_front();
            check_field("frame_kind",        8'(e.kind),                     8'(d[2:0]));
            check_field("handshake_step",    8'(e.step),                     8'(d[4:3]));
            check_field("frame_length",      e.length,                       d[12:5]);
            check_field("power_on",          8'(e.status.power_on),          8'(d[13]));
            check_field("pump_on",           8'(e.status.pump_on),           8'(d[14]));
            check_field("run_mode",          8'(e.status.run_mode),          8'(d[18:15]));
            check_field("fan_level",         8'(e.status.fan_level),         8'(d[25:19]));
            check_field("target_humidity",   8'(e.status.target_humidity),   8'(d[32:26]));
            check_field("measured_humidity", e.status.measured_humidity,     d[40:33]);
            check_field("fault_code",        e.status.fault_code,            d[48:41]);
            check_field("filter_request",    8'(e.status.filter_request),    8'(d[49]));
            check_field("padding",           8'd0,                           8'(d[55:50]));
        end
    endtask

    // Results are checked before the byte of the same edge is absorbed, since a
    // result can never come from a byte taken at that very edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame  = 1'b0;
            next_pos  = 8'd0;
            bytes_due = 8'd0;
            frame_len = 8'd0;
            for (int i = 0; i < NUM_SLOTS; i++)
                slots[i] = 8'd0;
            hs_step       = HS_NONE;
            latched       = '0;
            expected_reports.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata);
            pending_count = expected_reports.size();
        end
    end

endmodule

/* verif/testbench.sv */
// Top of the appliance frame receiver testbench: clock, reset, byte stimulus and verdict.
// Depends on afr_pkg, appliance_frame_receiver_top and afr_frame_checker.
`timescale 1ns / 1ps

module testbench;
    import afr_pkg::*;

    // A receiver hold long enough that both of the block's registers fill up
    // and the input side has to stall.
    localparam int STALL_CYCLES   = 300;
    // Cycles without any accepted request before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Random bytes sent after the directed part.
    localparam int RANDOM_BYTES   = 430;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    int          fail_count;
    int          pending_count;

    // Shared between the source and the sink: no_gaps switches off idling on
    // both sides, and long_hold asks the sink for one long stall.
    bit          no_gaps   = 1'b0;
    bit          long_hold = 1'b0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;

    // Body of the frame being built; index is the frame position.
    logic [7:0]  body [256];

    always #6 clk = ~clk;

    appliance_frame_receiver_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    afr_frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // A random byte that never restarts a frame.
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == SYNC_BYTE)
            b = ~b;
        return b;
    endfunction

    // Frame identifier at position 9: mostly one of the known codes.
    function automatic logic [7:0] pick_id();
        case ($urandom_range(0, 4))
            0:       return ID_NET_REQUEST;
            1:       return ID_HS_FIRST;
            2:       return ID_HS_SECOND;
            3:       return ID_HS_THIRD;
            default: return data_byte();
        endcase
    endfunction

    // Offers one byte as a request after a random gap and waits until the
    // block takes it. Inputs move at the falling edge only; when the next
    // request follows with no gap, tvalid simply stays high.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic fill_body();
        for (int i = 0; i < 256; i++)
            body[i] = data_byte();
    endtask

    // Sends a whole frame: sync, length, then positions 2 up to the length.
    task automatic send_body(input logic [7:0] len);
        send_byte(SYNC_BYTE);
        send_byte(len);
        for (int p = 2; p <= len; p++)
            send_byte(body[p]);
    endtask

    // Sink: for every result it draws a random stall, then keeps
    // tready high until a request is accepted. Once, on demand, it stalls for
    // a long stretch, counted here, while the source keeps sending.
    initial
    begin : sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = no_gaps ? 0 : $urandom_range(0, 4);
            if (long_hold)
            begin
                long_hold = 1'b0;
                hold      = STALL_CYCLES;
            end
            repeat (hold)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Watchdog: any accepted request on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin : source
        int         pick;
        int         cut;
        int         random_end;
        logic [7:0] len_sel;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Bytes outside a frame are ignored, including both extreme values.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);

        // Length bytes below the minimum or above the maximum drop the frame.
        send_byte(SYNC_BYTE);
        send_byte(8'd0);
        send_byte(SYNC_BYTE);
        send_byte(8'd1);
        send_byte(SYNC_BYTE);
        send_byte(8'd255);

        // Shortest frame, classified from the zeroed captures.
        fill_body();
        send_body(LEN_MIN);

        // Status frame with every captured status byte at all ones: setpoint clamps.
        fill_body();
        body[9]  = 8'h00;
        body[10] = ID_STATUS;
        body[11] = 8'hFF;
        body[12] = 8'hFF;
        body[13] = 8'hFF;
        body[17] = 8'hFF;
        body[19] = 8'hFF;
        body[26] = 8'hFF;
        body[31] = 8'hFF;
        send_body(8'd31);

        // Status frame with low values and the setpoint right at its limit.
        fill_body();
        body[9]  = 8'h00;
        body[10] = ID_STATUS;
        body[11] = 8'hFE;
        body[12] = 8'hF0;
        body[13] = 8'h80;
        body[17] = TARGET_MAX;
        body[19] = 8'h77;
        body[26] = 8'h00;
        body[31] = 8'h00;
        send_body(8'd32);

        // Setpoint one above its limit.
        fill_body();
        body[9]  = 8'h00;
        body[10] = ID_STATUS;
        body[17] = TARGET_MAX + 8'd1;
        send_body(8'd31);

        // A network request wins over a status identifier in the same frame.
        fill_body();
        body[9]  = ID_NET_REQUEST;
        body[10] = ID_STATUS;
        send_body(8'd10);

        // The three handshake replies in order, then an unknown frame.
        fill_body();
        body[9]  = ID_HS_FIRST;
        body[10] = 8'h00;
        send_body(8'd10);
        fill_body();
        body[9]  = ID_HS_SECOND;
        body[10] = 8'h00;
        send_body(8'd10);
        fill_body();
        body[9]  = ID_HS_THIRD;
        body[10] = 8'h00;
        send_body(8'd10);
        fill_body();
        body[9]  = 8'h11;
        body[10] = 8'h22;
        send_body(8'd10);

        // Short frame that reuses the captures of the status frame before it.
        fill_body();
        body[9]  = 8'h00;
        body[10] = ID_STATUS;
        send_body(8'd12);
        fill_body();
        send_body(8'd3);

        // Sync as a data byte restarts the frame; sync as the length byte too.
        send_byte(SYNC_BYTE);
        send_byte(8'd20);
        send_byte(data_byte());
        fill_body();
        send_body(8'd12);
        send_byte(SYNC_BYTE);
        fill_body();
        send_body(8'd10);

        // Longest frame the block accepts.
        fill_body();
        body[10] = ID_STATUS;
        send_body(LEN_MAX);

        // Back-to-back shortest frames while the sink stalls for a long time,
        // so the output fills and the input side backs up.
        no_gaps   = 1'b1;
        long_hold = 1'b1;
        repeat (20)
        begin
            send_byte(SYNC_BYTE);
            send_byte(LEN_MIN);
            send_byte(data_byte());
        end
        no_gaps = 1'b0;

        // Random part: mostly well-formed frames with random content, the rest
        // noise, bad lengths, cut-off frames and doubled syncs.
        random_end = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_end)
        begin
            if ($urandom_range(0, 29) == 0)
                no_gaps = ~no_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                fill_body();
                body[9] = pick_id();
                if ($urandom_range(0, 1) == 1)
                    body[10] = ID_STATUS;
                if ($urandom_range(0, 19) == 0)
                    len_sel = 8'($urandom_range(35, 254));
                else
                    len_sel = 8'($urandom_range(2, 34));
                send_body(len_sel);
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 88)
            begin
                send_byte(SYNC_BYTE);
                case ($urandom_range(0, 2))
                    0:       send_byte(8'd0);
                    1:       send_byte(8'd1);
                    default: send_byte(8'd255);
                endcase
            end
            else if (pick < 96)
            begin
                // Frame cut off before its last byte; the next sync restarts.
                fill_body();
                len_sel = 8'($urandom_range(4, 34));
                cut     = $urandom_range(2, int'(len_sel) - 1);
                send_byte(SYNC_BYTE);
                send_byte(len_sel);
                for (int p = 2; p < cut; p++)
                    send_byte(body[p]);
            end
            else
            begin
                send_byte(SYNC_BYTE);
                fill_body();
                body[9] = pick_id();
                send_body(8'($urandom_range(2, 34)));
            end
        end
        no_gaps = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain: every predicted result must arrive, then a short quiet spell
        // catches any result that should not be there.
        while (pending_count != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
